// File: sv/record_fifo_with_key_update_assert.svh
// Assertion macros for the record FIFO with keyed update.
// Used by the top level; needs a clock and an active-low reset at the call site.
`ifndef RECORD_FIFO_WITH_KEY_UPDATE_ASSERT_SVH
`define RECORD_FIFO_WITH_KEY_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define RFKU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RFKU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rfku_pkg.sv
// Types and codes shared by the record FIFO cells and the top level.
// No dependencies.
package rfku_pkg;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_UPD   = 2'd2,
        OP_PURGE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOMATCH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ENQ,
        CMD_DEQ,
        CMD_UPD,
        CMD_KILL,
        CMD_COMPACT
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_COMPACT
    } t_state;

    // code in the low bits, matching the stream packing
    typedef struct packed {
        logic signed [31:0] quantity;
        logic        [31:0] price;
        logic signed [31:0] code;
    } t_rec;

    // per-cell control from the top and the lower neighbor
    typedef struct packed {
        t_cmd cmd;
        logic sel;         // first matching cell on update
        logic prev_valid;  // lower neighbor holds a record
        logic move_lo;     // own record moves down this cycle
    } t_cell_ctl;

    // what a cell shows its lower neighbor
    typedef struct packed {
        t_rec rec;
        logic valid;
    } t_nbr;

    typedef struct packed {
        logic [2:0] pad;
        logic [4:0] entry_count;
        t_rec       rec;
    } t_result;

endpackage

// File: sv/record_fifo_with_key_update.sv
// Record FIFO with keyed update and purge: top level, control and result register.
// Depends on rfku_pkg, rfku_cell, rfku_count and the assertion macro header.
//
//  channel   | dir | tdata (low bit up)                          | tuser
//  ----------+-----+---------------------------------------------+-------------
//  s (input) | in  | item_code, item_price, item_quantity, pad  | op
//  m (result)| out | out_code, out_price, out_quantity,          | status
//            |     | entry_count, pad                            |
//
// Enqueue, dequeue and update take one transfer per cycle while the sink keeps up;
// the cells shift or compare in parallel. Purge first drops non-positive
// records, then runs compaction steps in which each record moves at most one
// cell toward the head per step.
// Reset (synchronous, active low) clears all valid bits: the queue is empty.
// Input is held off during compaction and while a result waits on a stalled sink.
module record_fifo_with_key_update #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,   // item_code, item_price, item_quantity, zero pad
    input  logic [1:0]   i_s_tuser,   // op
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // out_code, out_price, out_quantity, entry_count, pad
    output logic [1:0]   o_m_tuser    // status
);
    import rfku_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state r_state;
    t_state n_state;

    logic    r_m_valid;
    t_result r_result;
    t_result n_result;
    t_status r_status;
    t_status n_status;

    t_op  w_op;
    t_rec w_item;
    t_cmd w_cmd;
    logic w_accept;
    logic w_load_out;
    logic w_idle;
    logic w_packed;
    logic w_purge_in;
    logic w_quick_in;

    t_nbr                   w_self [QUEUE_DEPTH];
    t_nbr                   w_next [QUEUE_DEPTH];
    t_cell_ctl              w_ctl  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_first;
    logic [QUEUE_DEPTH-1:0] w_move;
    logic                   w_any_move;
    logic [CW-1:0]          w_cnt;
    logic [CW-1:0]          w_cnt_after;
    logic [CW+4:0]          w_cnt_wide;

    assign w_op       = t_op'(i_s_tuser);
    assign w_item     = t_rec'(i_s_tdata[95:0]);
    assign w_idle     = (r_state == S_IDLE);
    assign o_s_tready = w_idle && (!r_m_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_packed   = ((w_valid >> 1) & ~w_valid) == '0;
    assign w_purge_in = w_accept && (w_op == OP_PURGE);
    assign w_quick_in = w_accept && (w_op != OP_PURGE);

    // lowest set bit: first match from the head
    assign w_first    = w_match & (~w_match + QUEUE_DEPTH'(1));
    assign w_any_move = |w_move;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            assign w_valid[g] = w_self[g].valid;
            if (g == QUEUE_DEPTH - 1) begin : g_top
                assign w_next[g] = '0;
            end else begin : g_mid
                assign w_next[g] = w_self[g+1];
            end
            assign w_ctl[g].cmd        = w_cmd;
            assign w_ctl[g].sel        = w_first[g];
            assign w_ctl[g].prev_valid = (g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g-1];
            assign w_ctl[g].move_lo    = (g == 0) ? 1'b0 : w_move[(g == 0) ? 0 : g-1];

            rfku_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_item  (w_item),
                .i_next  (w_next[g]),
                .o_self  (w_self[g]),
                .o_match (w_match[g]),
                .o_move  (w_move[g])
            );
        end
    endgenerate

    rfku_count #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_count (
        .i_valid (w_valid),
        .o_count (w_cnt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_accept && w_op == OP_PURGE) n_state = S_COMPACT;
            S_COMPACT: if (!w_any_move) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_cmd      = CMD_HOLD;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_ENQ:   w_cmd = CMD_ENQ;
                        OP_DEQ:   w_cmd = CMD_DEQ;
                        OP_UPD:   w_cmd = CMD_UPD;
                        OP_PURGE: w_cmd = CMD_KILL;
                        default:  w_cmd = CMD_HOLD;
                    endcase
                    w_load_out = (w_op != OP_PURGE);
                end
            end
            S_COMPACT: begin
                w_cmd      = CMD_COMPACT;
                w_load_out = !w_any_move;
            end
            default: ;
        endcase
    end

    // result fields
    always_comb begin
        n_status    = STAT_OK;
        w_cnt_after = w_cnt;
        n_result    = '0;
        if (r_state == S_IDLE) begin
            case (w_op)
                OP_ENQ: begin
                    if (w_valid[QUEUE_DEPTH-1]) begin
                        n_status = STAT_FULL;
                    end else begin
                        w_cnt_after = w_cnt + CW'(1);
                    end
                end
                OP_DEQ: begin
                    if (!w_valid[0]) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_result.rec = w_self[0].rec;
                        w_cnt_after  = w_cnt - CW'(1);
                    end
                end
                OP_UPD: begin
                    if (!(|w_match)) n_status = STAT_NOMATCH;
                end
                default: ;
            endcase
        end
        w_cnt_wide           = (CW+5)'(w_cnt_after);
        n_result.entry_count = w_cnt_wide[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_result <= n_result;
            r_status <= n_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_result;
    assign o_m_tuser  = r_status;

`include "record_fifo_with_key_update_assert.svh"

    `RFKU_ASSERT_NOW(a_packed_idle, i_clk, i_rst_n, w_idle, w_packed, "valid bits not packed")
    `RFKU_ASSERT_NOW(a_no_take, i_clk, i_rst_n, !w_idle, !o_s_tready, "ready in compaction")
    `RFKU_ASSERT_NEXT(a_quick_result, i_clk, i_rst_n, w_quick_in, o_m_tvalid, "result missing")
    `RFKU_ASSERT_NEXT(a_purge, i_clk, i_rst_n, w_purge_in, !(w_idle || o_m_tvalid), "no compaction")

endmodule

// File: sv/rfku_cell.sv
// One storage cell of the record FIFO: a record and its valid bit.
// Depends on rfku_pkg.
module rfku_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfku_pkg::t_cell_ctl i_ctl,
    input  rfku_pkg::t_rec    i_item,
    input  rfku_pkg::t_nbr    i_next,
    output rfku_pkg::t_nbr    o_self,
    output logic              o_match,
    output logic              o_move
);
    import rfku_pkg::*;

    logic r_valid;
    logic n_valid;
    t_rec r_rec;
    t_rec n_rec;
    logic w_positive;

    assign w_positive = (r_rec.quantity != 32'sd0) && !r_rec.quantity[31];
    assign o_match    = r_valid && (r_rec.code == i_item.code);
    // upper neighbor's record drops into this empty slot
    assign o_move     = !r_valid && i_next.valid;
    assign o_self     = '{rec: r_rec, valid: r_valid};

    always_comb begin
        n_valid = r_valid;
        n_rec   = r_rec;
        unique case (i_ctl.cmd)
            CMD_HOLD: ;
            CMD_ENQ: begin
                if (!r_valid && i_ctl.prev_valid) begin
                    n_valid = 1'b1;
                    n_rec   = i_item;
                end
            end
            CMD_DEQ: begin
                n_valid = i_next.valid;
                n_rec   = i_next.rec;
            end
            CMD_UPD: begin
                if (i_ctl.sel) begin
                    n_rec.price    = i_item.price;
                    n_rec.quantity = i_item.quantity;
                end
            end
            CMD_KILL: begin
                n_valid = r_valid && w_positive;
            end
            CMD_COMPACT: begin
                if (o_move) begin
                    n_valid = 1'b1;
                    n_rec   = i_next.rec;
                end else if (i_ctl.move_lo) begin
                    n_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// File: sv/rfku_count.sv
// Turns the packed-from-head valid bits of the cell row into a record count.
// Depends on nothing; expects valid bits filled from index 0 upward.
module rfku_count #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic [DEPTH-1:0] i_valid,
    output logic [CW-1:0]    o_count
);
    logic [DEPTH:0] w_ext;

    assign w_ext = {1'b0, i_valid};

    // at most one edge from filled to empty; OR in its position
    always_comb begin
        o_count = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_ext[i] && !w_ext[i+1]) begin
                o_count = o_count | CW'(i + 1);
            end
        end
    end

endmodule
